// ===== rtl/core/pcp_pkg.sv =====
// Package: widths, payload types and pipeline sideband types for particle contact projection
package pcp_pkg;

  // margin, distance and penetration width (Q.16 integers)
  localparam int MW   = 27;
  // squared distance width
  localparam int D2W  = 2 * MW;
  // first quotient a = |e| * p * 256 / d
  localparam int QW1  = 35;
  // remainder width of first divider
  localparam int DRW1 = MW + 1;
  // mass sum width
  localparam int SW   = 17;
  // numerator of share division after the >> 8
  localparam int N2W  = 44;
  // share quotient width
  localparam int QW2  = 28;
  // remainder width of share divider
  localparam int DRW2 = SW + 1;
  // square root remainder width
  localparam int SQRW = MW + 3;
  // radius sum times scale
  localparam int PW   = 41;
  // share numerator a*mk + 128*S before the >> 8
  localparam int PRW  = QW1 + 17;

  localparam logic [15:0] MARGIN_SCALE_RESET = 16'd17203;
  localparam logic [PW-1:0] MARGIN_ROUND     = PW'(8192);
  localparam int MARGIN_SHIFT                = 14;

  typedef struct packed {
    logic signed [31:0] pos_i_x;
    logic signed [31:0] pos_i_y;
    logic signed [31:0] pos_i_z;
    logic signed [31:0] pos_j_x;
    logic signed [31:0] pos_j_y;
    logic signed [31:0] pos_j_z;
    logic [15:0]        inv_mass_i;
    logic [15:0]        inv_mass_j;
    logic [23:0]        radius_i;
    logic [23:0]        radius_j;
  } pcp_in_t;

  typedef struct packed {
    logic signed [31:0] delta_i_x;
    logic signed [31:0] delta_i_y;
    logic signed [31:0] delta_i_z;
    logic signed [31:0] delta_j_x;
    logic signed [31:0] delta_j_y;
    logic signed [31:0] delta_j_z;
    logic               contact;
    logic               degenerate;
  } pcp_out_t;

  // per-request flags and masses that ride along the whole pipeline
  typedef struct packed {
    logic [2:0]  neg;
    logic        contact;
    logic        degen;
    logic [15:0] mi;
    logic [15:0] mj;
  } pcp_side_t;

  // extra sideband needed until the penetration is formed
  typedef struct packed {
    pcp_side_t           side;
    logic [2:0][MW-1:0]  mag;
    logic [MW-1:0]       m;
  } pcp_sq_side_t;

endpackage

// ===== rtl/core/pcp_front.sv =====
// Front end: differences, margin, squared distance and contact decision (4 stages)
module pcp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  v_in,
  input  pcp_pkg::pcp_in_t      data_in,
  input  logic [15:0]           scale,
  output logic                  v_out,
  output logic [pcp_pkg::D2W-1:0] d2_out,
  output pcp_pkg::pcp_sq_side_t side_out
);
  import pcp_pkg::*;

  // stage 1 regs
  logic                     v1;
  logic signed [2:0][32:0]  dif1;
  logic [PW-1:0]            prod1;
  logic [15:0]              mi1, mj1;
  // stage 2 regs
  logic                     v2;
  logic [2:0][MW-1:0]       mag2;
  logic [2:0]               lt2, neg2;
  logic [MW-1:0]            m2;
  logic [15:0]              mi2, mj2;
  // stage 3 regs
  logic                     v3;
  logic [2:0][D2W-1:0]      sq3;
  logic [D2W-1:0]           mm3;
  logic                     lt3;
  logic [2:0]               neg3;
  logic [2:0][MW-1:0]       mag3;
  logic [MW-1:0]            m3;
  logic [15:0]              mi3, mj3;

  logic signed [2:0][32:0]  dif_c;
  logic [24:0]              rsum_c;
  logic [MW-1:0]            m_c;
  logic [2:0][32:0]         magf_c;
  logic [D2W+1:0]           sum_c;

  // position differences and radius sum
  always_comb begin
    dif_c[0] = {data_in.pos_i_x[31], data_in.pos_i_x} - {data_in.pos_j_x[31], data_in.pos_j_x};
    dif_c[1] = {data_in.pos_i_y[31], data_in.pos_i_y} - {data_in.pos_j_y[31], data_in.pos_j_y};
    dif_c[2] = {data_in.pos_i_z[31], data_in.pos_i_z} - {data_in.pos_j_z[31], data_in.pos_j_z};
    rsum_c   = {1'b0, data_in.radius_i} + {1'b0, data_in.radius_j};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v_in;
    end
    if (en) begin
      dif1  <= dif_c;
      prod1 <= PW'(rsum_c) * PW'(scale);
      mi1   <= data_in.inv_mass_i;
      mj1   <= data_in.inv_mass_j;
    end
  end

  // margin rounding, magnitudes, per-axis early test
  always_comb begin
    m_c = MW'((prod1 + MARGIN_ROUND) >> MARGIN_SHIFT);
    for (int k = 0; k < 3; k++) begin
      magf_c[k] = dif1[k][32] ? 33'(-dif1[k]) : 33'(dif1[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag2[k] <= magf_c[k][MW-1:0];
        lt2[k]  <= magf_c[k] < 33'(m_c);
        neg2[k] <= dif1[k][32];
      end
      m2  <= m_c;
      mi2 <= mi1;
      mj2 <= mj1;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq3[k] <= D2W'(mag2[k]) * D2W'(mag2[k]);
      end
      mm3  <= D2W'(m2) * D2W'(m2);
      lt3  <= &lt2;
      neg3 <= neg2;
      mag3 <= mag2;
      m3   <= m2;
      mi3  <= mi2;
      mj3  <= mj2;
    end
  end

  // sum and contact decision
  assign sum_c = (D2W+2)'(sq3[0]) + (D2W+2)'(sq3[1]) + (D2W+2)'(sq3[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v3;
    end
    if (en) begin
      d2_out                <= sum_c[D2W-1:0];
      side_out.side.contact <= lt3 && (sum_c < (D2W+2)'(mm3));
      side_out.side.degen   <= (sum_c == '0) || ((mi3 == '0) && (mj3 == '0));
      side_out.side.neg     <= neg3;
      side_out.side.mi      <= mi3;
      side_out.side.mj      <= mj3;
      side_out.mag          <= mag3;
      side_out.m            <= m3;
    end
  end

endmodule

// ===== rtl/core/pcp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage
module pcp_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v_in,
  input  logic [pcp_pkg::D2W-1:0] x_in,
  input  pcp_pkg::pcp_sq_side_t   side_in,
  output logic                    v_out,
  output logic [pcp_pkg::MW-1:0]  root_out,
  output pcp_pkg::pcp_sq_side_t   side_out
);
  import pcp_pkg::*;

  logic            vq   [0:MW];
  logic [D2W-1:0]  xq   [0:MW];
  logic [SQRW-1:0] remq [0:MW];
  logic [MW-1:0]   rootq[0:MW];
  pcp_sq_side_t    sq   [0:MW];

  assign vq[0]    = v_in;
  assign xq[0]    = x_in;
  assign remq[0]  = '0;
  assign rootq[0] = '0;
  assign sq[0]    = side_in;

  for (genvar s = 0; s < MW; s++) begin : g_step
    logic [SQRW-1:0] r2, trial;
    logic            take;

    // bring down two radicand bits, try root*4+1
    always_comb begin
      r2    = {remq[s][SQRW-3:0], xq[s][D2W-1 -: 2]};
      trial = SQRW'({rootq[s], 2'b01});
      take  = r2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[s+1] <= 1'b0;
      end else if (en) begin
        vq[s+1] <= vq[s];
      end
      if (en) begin
        xq[s+1]    <= {xq[s][D2W-3:0], 2'b00};
        remq[s+1]  <= take ? (r2 - trial) : r2;
        rootq[s+1] <= {rootq[s][MW-2:0], take};
        sq[s+1]    <= sq[s];
      end
    end
  end

  assign v_out    = vq[MW];
  assign root_out = rootq[MW];
  assign side_out = sq[MW];

endmodule

// ===== rtl/core/pcp_quot.sv =====
// Penetration, |e|*p product and pipelined division by d (three lanes)
module pcp_quot (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            v_in,
  input  logic [pcp_pkg::MW-1:0]          d_in,
  input  pcp_pkg::pcp_sq_side_t           side_in,
  output logic                            v_out,
  output logic [2:0][pcp_pkg::QW1-1:0]    a_out,
  output pcp_pkg::pcp_side_t              side_out
);
  import pcp_pkg::*;

  logic                    vp;
  logic [2:0][D2W-1:0]     nump;
  logic [MW-1:0]           dp;
  pcp_side_t               sidep;
  logic [MW-1:0]           p_c;

  // penetration and numerator product
  assign p_c = side_in.m - d_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= v_in;
    end
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nump[k] <= D2W'(side_in.mag[k]) * D2W'(p_c);
      end
      dp    <= d_in;
      sidep <= side_in.side;
    end
  end

  // restoring divider, one quotient bit per stage; numerator is nump << 8
  logic                      vd   [0:QW1];
  logic [2:0][DRW1-1:0]      remd [0:QW1];
  logic [2:0][QW1-1:0]       lowd [0:QW1];
  logic [MW-1:0]             dd   [0:QW1];
  pcp_side_t                 sd   [0:QW1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      remd[0][k] = DRW1'(nump[k][D2W-1:MW]);
      lowd[0][k] = {nump[k][MW-1:0], 8'h00};
    end
  end
  assign vd[0] = vp;
  assign dd[0] = dp;
  assign sd[0] = sidep;

  for (genvar s = 0; s < QW1; s++) begin : g_step
    logic [2:0][DRW1-1:0] r2;
    logic [2:0]           take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k]   = {remd[s][k][DRW1-2:0], lowd[s][k][QW1-1]};
        take[k] = r2[k] >= DRW1'(dd[s]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (en) begin
        vd[s+1] <= vd[s];
      end
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          remd[s+1][k] <= take[k] ? (r2[k] - DRW1'(dd[s])) : r2[k];
          lowd[s+1][k] <= {lowd[s][k][QW1-2:0], take[k]};
        end
        dd[s+1] <= dd[s];
        sd[s+1] <= sd[s];
      end
    end
  end

  assign v_out    = vd[QW1];
  assign a_out    = lowd[QW1];
  assign side_out = sd[QW1];

endmodule

// ===== rtl/core/pcp_share.sv =====
// Mass share: rounded (a*mk)/(256*S) over six lanes, sign and output register
module pcp_share (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         v_in,
  input  logic [2:0][pcp_pkg::QW1-1:0] a_in,
  input  pcp_pkg::pcp_side_t           side_in,
  output logic                         v_out,
  output pcp_pkg::pcp_out_t            data_out
);
  import pcp_pkg::*;

  logic                 vm;
  logic [5:0][N2W-1:0]  n2m;
  logic [SW-1:0]        sm;
  pcp_side_t            sidem;
  logic [SW-1:0]        s_c;
  logic [5:0][PRW-1:0]  pr_c;

  // numerators a*mk + 128*S, lanes 0..2 first particle, 3..5 second
  always_comb begin
    s_c = SW'(side_in.mi) + SW'(side_in.mj);
    for (int k = 0; k < 3; k++) begin
      pr_c[k]   = PRW'(a_in[k]) * PRW'(side_in.mi) + (PRW'(s_c) << 7);
      pr_c[k+3] = PRW'(a_in[k]) * PRW'(side_in.mj) + (PRW'(s_c) << 7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= v_in;
    end
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        n2m[k] <= pr_c[k][N2W+7:8];
      end
      sm    <= s_c;
      sidem <= side_in;
    end
  end

  // restoring divider by S
  logic                 vd   [0:QW2];
  logic [5:0][DRW2-1:0] remd [0:QW2];
  logic [5:0][QW2-1:0]  lowd [0:QW2];
  logic [SW-1:0]        sd   [0:QW2];
  pcp_side_t            fd   [0:QW2];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      remd[0][k] = DRW2'(n2m[k][N2W-1:QW2]);
      lowd[0][k] = n2m[k][QW2-1:0];
    end
  end
  assign vd[0] = vm;
  assign sd[0] = sm;
  assign fd[0] = sidem;

  for (genvar s = 0; s < QW2; s++) begin : g_step
    logic [5:0][DRW2-1:0] r2;
    logic [5:0]           take;

    always_comb begin
      for (int k = 0; k < 6; k++) begin
        r2[k]   = {remd[s][k][DRW2-2:0], lowd[s][k][QW2-1]};
        take[k] = r2[k] >= DRW2'(sd[s]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (en) begin
        vd[s+1] <= vd[s];
      end
      if (en) begin
        for (int k = 0; k < 6; k++) begin
          remd[s+1][k] <= take[k] ? (r2[k] - DRW2'(sd[s])) : r2[k];
          lowd[s+1][k] <= {lowd[s][k][QW2-2:0], take[k]};
        end
        sd[s+1] <= sd[s];
        fd[s+1] <= fd[s];
      end
    end
  end

  // sign and zeroing; magnitudes stay below 2^28 so no clamp is reached
  pcp_side_t           fl;
  logic                zero_c;
  logic [5:0][31:0]    dl_c;

  assign fl     = fd[QW2];
  assign zero_c = !fl.contact || fl.degen;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dl_c[k]   = (fl.neg[k] ? -32'(lowd[QW2][k]) : 32'(lowd[QW2][k]));
      dl_c[k+3] = (fl.neg[k] ? 32'(lowd[QW2][k+3]) : -32'(lowd[QW2][k+3]));
      if (zero_c) begin
        dl_c[k]   = '0;
        dl_c[k+3] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= vd[QW2];
    end
    if (en) begin
      data_out.delta_i_x  <= dl_c[0];
      data_out.delta_i_y  <= dl_c[1];
      data_out.delta_i_z  <= dl_c[2];
      data_out.delta_j_x  <= dl_c[3];
      data_out.delta_j_y  <= dl_c[4];
      data_out.delta_j_z  <= dl_c[5];
      data_out.contact    <= fl.contact;
      data_out.degenerate <= fl.contact && fl.degen;
    end
  end

endmodule

// ===== rtl/core/particle_contact_projection.sv =====
// Top level: particle pair contact projection pipeline
//
// Requests arrive on in_valid/in_ready/in_data, one particle pair each, and
// leave on out_valid/out_ready/out_data, one result per request, in order.
// The margin scale register (unsigned Q2.14) is written through
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high. Write it only
// while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. Depth:
// 97 register stages (4 front stages, 27 square-root stages, 1 + 35 stages
// for the division by distance, 1 + 28 stages for the mass-share division,
// and the output register); the two bit-serial dividers and the root set
// the depth.
// The whole pipeline advances together: when out_valid is high and
// out_ready low, every stage holds and in_ready drops in the same cycle,
// so nothing is lost or repeated. Bubbles travel with their valid bits.
// Reset (rst, synchronous) clears all valid bits and sets the margin scale
// to 1.05.
module particle_contact_projection (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcp_pkg::pcp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcp_pkg::pcp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import pcp_pkg::*;

  logic           en;
  logic [15:0]    margin_scale;

  logic           v_f;
  logic [D2W-1:0] d2_f;
  pcp_sq_side_t   side_f;
  logic           v_r;
  logic [MW-1:0]  root_r;
  pcp_sq_side_t   side_r;
  logic           v_q;
  logic [2:0][QW1-1:0] a_q;
  pcp_side_t      side_q;

  // global advance
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // margin scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      margin_scale <= MARGIN_SCALE_RESET;
    end else if (cfg_valid) begin
      margin_scale <= cfg_data;
    end
  end

  pcp_front u_front (
    .clk(clk), .rst(rst), .en(en), .v_in(in_valid), .data_in(in_data),
    .scale(margin_scale), .v_out(v_f), .d2_out(d2_f), .side_out(side_f)
  );

  pcp_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .v_in(v_f), .x_in(d2_f), .side_in(side_f),
    .v_out(v_r), .root_out(root_r), .side_out(side_r)
  );

  pcp_quot u_quot (
    .clk(clk), .rst(rst), .en(en), .v_in(v_r), .d_in(root_r), .side_in(side_r),
    .v_out(v_q), .a_out(a_q), .side_out(side_q)
  );

  pcp_share u_share (
    .clk(clk), .rst(rst), .en(en), .v_in(v_q), .a_in(a_q), .side_in(side_q),
    .v_out(out_valid), .data_out(out_data)
  );

  // degenerate only flags a contact
  a_degen_contact: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.contact)
    else $error("degenerate without contact");

  // no contact means no correction
  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.contact |->
      out_data.delta_i_x == '0 && out_data.delta_i_y == '0 &&
      out_data.delta_i_z == '0 && out_data.delta_j_x == '0 &&
      out_data.delta_j_y == '0 && out_data.delta_j_z == '0)
    else $error("nonzero correction without contact");

  // a waiting result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output stalled");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
